// File: rtl/srep_pkg.sv
package srep_pkg;

    localparam int STACK_DEPTH_DEF = 64;

    localparam logic [7:0] SYM_A     = 8'h61;
    localparam logic [7:0] SYM_PLUS  = 8'h2B;
    localparam logic [7:0] SYM_TIMES = 8'h2A;
    localparam logic [7:0] SYM_LPAR  = 8'h28;
    localparam logic [7:0] SYM_RPAR  = 8'h29;
    localparam logic [7:0] SYM_E     = 8'h45;
    localparam logic [7:0] SYM_SPACE = 8'h20;

    localparam logic [2:0] ACT_SHIFT = 3'd0;
    localparam logic [2:0] ACT_RED_A = 3'd1;
    localparam logic [2:0] ACT_RED_PLUS = 3'd2;
    localparam logic [2:0] ACT_RED_TIMES = 3'd3;
    localparam logic [2:0] ACT_RED_PAREN = 3'd4;
    localparam logic [2:0] ACT_OVERFLOW = 3'd5;
    localparam logic [2:0] ACT_NONE = 3'd7;

    typedef struct packed {
        logic       is_space;
        logic       fin;
        logic [7:0] chr;
    } t_qword;

endpackage

// File: rtl/shift_reduce_expr_parser.sv
// Channel  Valid    Stall    Word
// in       i_valid  o_stall  i_char_in, i_final_char
// out      o_valid  i_stall  o_action, o_depth, o_top_symbol, o_accepted, o_last_of_run
//
// A character leaves the queue in the idle state and is pushed in the shift state; each
// single-symbol reduction is done in the reduce state, and each three-symbol reduction
// also passes the fill state (stack memory read to refill the cached top entries).
// Spaces not ending a string are dropped in the front queue and never reach the engine.
// Reset is synchronous, active low; it empties the stack, no clearing pass.
// A two-word queue lets input be taken while the engine waits on a stalled result.
module shift_reduce_expr_parser
    import srep_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_in,
    input  logic       i_final_char,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_action,
    output logic [6:0] o_depth,
    output logic [7:0] o_top_symbol,
    output logic       o_accepted,
    output logic       o_last_of_run
);

    logic   w_qvalid;
    t_qword w_qword;
    logic   w_qpop;

    srep_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_char_in    (i_char_in),
        .i_final_char (i_final_char),
        .o_qvalid     (w_qvalid),
        .o_qword      (w_qword),
        .i_qpop       (w_qpop)
    );

    srep_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_qvalid      (w_qvalid),
        .i_qword       (w_qword),
        .o_qpop        (w_qpop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_action      (o_action),
        .o_depth       (o_depth),
        .o_top_symbol  (o_top_symbol),
        .o_accepted    (o_accepted),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// File: rtl/srep_front.sv
module srep_front
    import srep_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_in,
    input  logic       i_final_char,
    output logic       o_qvalid,
    output t_qword     o_qword,
    input  logic       i_qpop
);

    t_qword     r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    logic   w_full;
    logic   w_push;
    logic   w_pop;
    t_qword w_word;

    assign w_full   = (r_cnt == 2'd2);
    assign o_stall  = w_full;
    assign o_qvalid = (r_cnt != 2'd0);
    assign o_qword  = r_q[r_rp];

    // drop plain spaces here; a space that ends the string still clears the stack
    assign w_push = i_valid && !w_full && ((i_char_in != SYM_SPACE) || i_final_char);
    assign w_pop  = i_qpop && (r_cnt != 2'd0);

    always_comb begin
        w_word.is_space = (i_char_in == SYM_SPACE);
        w_word.fin      = i_final_char;
        w_word.chr      = i_char_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_word;
                r_wp      <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/srep_back.sv
module srep_back
    import srep_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_qvalid,
    input  t_qword     i_qword,
    output logic       o_qpop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_action,
    output logic [6:0] o_depth,
    output logic [7:0] o_top_symbol,
    output logic       o_accepted,
    output logic       o_last_of_run
);

    localparam int DW  = $clog2(STACK_DEPTH + 1);
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int DXW = DW + 7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_RED,
        S_FILL
    } t_state;

    function automatic logic [2:0] red_code(
        input logic [DW-1:0] d,
        input logic [7:0]    s0,
        input logic [7:0]    s1,
        input logic [7:0]    s2
    );
        logic [2:0] code;
        code = ACT_NONE;
        if ((d >= DW'(1)) && (s0 == SYM_A)) begin
            code = ACT_RED_A;
        end else if (d >= DW'(3)) begin
            if ((s0 == SYM_E) && (s1 == SYM_PLUS) && (s2 == SYM_E)) begin
                code = ACT_RED_PLUS;
            end else if ((s0 == SYM_E) && (s1 == SYM_TIMES) && (s2 == SYM_E)) begin
                code = ACT_RED_TIMES;
            end else if ((s0 == SYM_RPAR) && (s1 == SYM_E) && (s2 == SYM_LPAR)) begin
                code = ACT_RED_PAREN;
            end
        end
        return code;
    endfunction

    logic [7:0]    r_mem [STACK_DEPTH];
    t_state        r_state;
    logic [DW-1:0] r_depth;
    logic [7:0]    r_t0;
    logic [7:0]    r_t1;
    logic [7:0]    r_t2;
    logic [7:0]    r_chr;
    logic          r_fin;
    logic [1:0]    r_cnt;
    logic [2:0]    r_code;
    logic [7:0]    r_rd1;
    logic [7:0]    r_rd2;
    logic          r_ovalid;
    logic [2:0]    r_oaction;
    logic [6:0]    r_odepth;
    logic [7:0]    r_otop;
    logic          r_oacc;
    logic          r_olast;

    logic          w_out_free;
    logic          w_emit;
    logic          w_full;
    logic [DW-1:0] w_dp1;
    logic [DW-1:0] w_dm1;
    logic [DW-1:0] w_dm2;
    logic [DW-1:0] w_dm3;
    logic [DW-1:0] w_dm4;
    logic [DW-1:0] w_dm5;
    logic [2:0]    w_cur_code;
    logic [2:0]    w_sh_code;
    logic [2:0]    w_ra_code;
    logic [2:0]    w_fl_code;
    logic          w_sh_last;
    logic          w_ra_last;
    logic          w_fl_last;
    logic [DXW-1:0] w_cur_dx;
    logic [DXW-1:0] w_dp1_dx;
    logic [DXW-1:0] w_dm2_dx;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;

    assign w_out_free = !r_ovalid || !i_stall;
    assign w_emit     = w_out_free && ((r_state == S_SHIFT) || (r_state == S_FILL) ||
                        ((r_state == S_RED) && (w_cur_code == ACT_RED_A)));
    assign w_full     = (r_depth >= DW'(STACK_DEPTH));
    assign w_dp1      = r_depth + DW'(1);
    assign w_dm1      = r_depth - DW'(1);
    assign w_dm2      = r_depth - DW'(2);
    assign w_dm3      = r_depth - DW'(3);
    assign w_dm4      = r_depth - DW'(4);
    assign w_dm5      = r_depth - DW'(5);
    assign w_cur_dx   = DXW'(r_depth);
    assign w_dp1_dx   = DXW'(w_dp1);
    assign w_dm2_dx   = DXW'(w_dm2);

    assign w_cur_code = red_code(r_depth, r_t0, r_t1, r_t2);
    assign w_sh_code  = red_code(w_dp1, r_chr, r_t0, r_t1);
    assign w_ra_code  = red_code(r_depth, SYM_E, r_t1, r_t2);
    assign w_fl_code  = red_code(w_dm2, SYM_E, r_rd1, r_rd2);
    assign w_sh_last  = (w_sh_code == ACT_NONE);
    assign w_ra_last  = (r_cnt == 2'd2) || (w_ra_code == ACT_NONE);
    assign w_fl_last  = (r_cnt == 2'd2) || (w_fl_code == ACT_NONE);

    assign o_qpop        = (r_state == S_IDLE) && i_qvalid;
    assign o_valid       = r_ovalid;
    assign o_action      = r_oaction;
    assign o_depth       = r_odepth;
    assign o_top_symbol  = r_otop;
    assign o_accepted    = r_oacc;
    assign o_last_of_run = r_olast;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_depth[AW-1:0];
        w_wdata = r_chr;
        case (r_state)
            S_SHIFT: begin
                w_we = w_out_free && !w_full;
            end
            S_RED: begin
                w_we    = w_out_free && (w_cur_code == ACT_RED_A);
                w_waddr = w_dm1[AW-1:0];
                w_wdata = SYM_E;
            end
            S_FILL: begin
                w_we    = w_out_free;
                w_waddr = w_dm3[AW-1:0];
                w_wdata = SYM_E;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (r_state == S_RED) begin
            r_rd1 <= r_mem[w_dm4[AW-1:0]];
            r_rd2 <= r_mem[w_dm5[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_depth  <= '0;
            r_cnt    <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= w_emit || (r_ovalid && i_stall);
            case (r_state)
                S_IDLE: begin
                    if (i_qvalid) begin
                        r_chr <= i_qword.chr;
                        r_fin <= i_qword.fin;
                        if (i_qword.is_space) begin
                            if (i_qword.fin) begin
                                r_depth <= '0;
                            end
                        end else begin
                            r_state <= S_SHIFT;
                        end
                    end
                end
                S_SHIFT: begin
                    if (w_out_free) begin
                        if (w_full) begin
                            r_oaction <= ACT_OVERFLOW;
                            r_odepth  <= w_cur_dx[6:0];
                            r_otop    <= r_t0;
                            r_olast   <= 1'b1;
                            r_oacc    <= r_fin && (r_depth == DW'(1)) && (r_t0 == SYM_E);
                            r_state   <= S_IDLE;
                            if (r_fin) begin
                                r_depth <= '0;
                            end
                        end else begin
                            r_t0      <= r_chr;
                            r_t1      <= r_t0;
                            r_t2      <= r_t1;
                            r_cnt     <= 2'd1;
                            r_oaction <= ACT_SHIFT;
                            r_odepth  <= w_dp1_dx[6:0];
                            r_otop    <= r_chr;
                            r_olast   <= w_sh_last;
                            r_oacc    <= w_sh_last && r_fin && (w_dp1 == DW'(1)) &&
                                         (r_chr == SYM_E);
                            if (w_sh_last) begin
                                r_state <= S_IDLE;
                                r_depth <= r_fin ? '0 : w_dp1;
                            end else begin
                                r_state <= S_RED;
                                r_depth <= w_dp1;
                            end
                        end
                    end
                end
                S_RED: begin
                    if (w_cur_code == ACT_RED_A) begin
                        if (w_out_free) begin
                            r_t0      <= SYM_E;
                            r_cnt     <= r_cnt + 2'd1;
                            r_oaction <= ACT_RED_A;
                            r_odepth  <= w_cur_dx[6:0];
                            r_otop    <= SYM_E;
                            r_olast   <= w_ra_last;
                            r_oacc    <= w_ra_last && r_fin && (r_depth == DW'(1));
                            if (w_ra_last) begin
                                r_state <= S_IDLE;
                                if (r_fin) begin
                                    r_depth <= '0;
                                end
                            end
                        end
                    end else if (w_cur_code == ACT_NONE) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_code  <= w_cur_code;
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    if (w_out_free) begin
                        r_t0      <= SYM_E;
                        r_t1      <= r_rd1;
                        r_t2      <= r_rd2;
                        r_cnt     <= r_cnt + 2'd1;
                        r_oaction <= r_code;
                        r_odepth  <= w_dm2_dx[6:0];
                        r_otop    <= SYM_E;
                        r_olast   <= w_fl_last;
                        r_oacc    <= w_fl_last && r_fin && (w_dm2 == DW'(1));
                        if (w_fl_last) begin
                            r_state <= S_IDLE;
                            r_depth <= r_fin ? '0 : w_dm2;
                        end else begin
                            r_state <= S_RED;
                            r_depth <= w_dm2;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: sim/tb_shift_reduce_expr_parser.sv
`timescale 1ns / 1ps

module tb_shift_reduce_expr_parser
    import srep_pkg::*;
();

    localparam int STACK_N      = STACK_DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int TAIL_CYCLES  = 40;
    localparam int RANDOM_CHARS = 30;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_CHARS   = 40;

    typedef struct packed {
        logic [2:0] action;
        logic [6:0] depth;
        logic [7:0] top_symbol;
        logic       accepted;
        logic       last_of_run;
    } t_parse_word;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_char_in;
    logic       i_final_char;
    logic       o_valid;
    logic       i_stall;
    logic [2:0] o_action;
    logic [6:0] o_depth;
    logic [7:0] o_top_symbol;
    logic       o_accepted;
    logic       o_last_of_run;

    logic [7:0]  shadow_stack [STACK_N];
    int unsigned shadow_depth = 0;
    t_parse_word words_due [$];
    logic [7:0]  text_buf [$];
    int          err_count   = 0;
    int          chars_sent  = 0;
    int          hold_len    = 0;
    bit          src_jitter  = 1'b0;
    bit          sink_jitter = 1'b0;

    shift_reduce_expr_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_char_in     (i_char_in),
        .i_final_char  (i_final_char),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_action      (o_action),
        .o_depth       (o_depth),
        .o_top_symbol  (o_top_symbol),
        .o_accepted    (o_accepted),
        .o_last_of_run (o_last_of_run)
    );

    always #6 i_clk = ~i_clk;

    function automatic int idle_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] shadow_top();
        return (shadow_depth == 0) ? 8'h00 : shadow_stack[shadow_depth - 1];
    endfunction

    function automatic t_parse_word word_now(input logic [2:0] act);
        t_parse_word w;
        w.action      = act;
        w.depth       = shadow_depth[6:0];
        w.top_symbol  = shadow_top();
        w.accepted    = 1'b0;
        w.last_of_run = 1'b0;
        return w;
    endfunction

    function automatic bit fold_triple(input logic [7:0] x, input logic [7:0] mid,
                                       input logic [7:0] y);
        if (shadow_depth < 3) return 1'b0;
        if (shadow_stack[shadow_depth - 1] != y || shadow_stack[shadow_depth - 2] != mid ||
            shadow_stack[shadow_depth - 3] != x) return 1'b0;
        shadow_depth -= 2;
        shadow_stack[shadow_depth - 1] = SYM_E;
        return 1'b1;
    endfunction

    function automatic logic [2:0] reduce_top();
        if (shadow_depth >= 1 && shadow_stack[shadow_depth - 1] == SYM_A) begin
            shadow_stack[shadow_depth - 1] = SYM_E;
            return ACT_RED_A;
        end
        if (fold_triple(SYM_E, SYM_PLUS, SYM_E)) return ACT_RED_PLUS;
        if (fold_triple(SYM_E, SYM_TIMES, SYM_E)) return ACT_RED_TIMES;
        if (fold_triple(SYM_LPAR, SYM_E, SYM_RPAR)) return ACT_RED_PAREN;
        return ACT_NONE;
    endfunction

    task automatic parse_char(input logic [7:0] c, input logic fin);
        t_parse_word run [3];
        int          n;
        logic [2:0]  act;
        n = 0;
        if (c != SYM_SPACE) begin
            if (shadow_depth >= STACK_N) begin
                run[0] = word_now(ACT_OVERFLOW);
                n = 1;
            end else begin
                shadow_stack[shadow_depth] = c;
                shadow_depth++;
                run[0] = word_now(ACT_SHIFT);
                n = 1;
                act = reduce_top();
                if (act != ACT_NONE) begin
                    run[1] = word_now(act);
                    n = 2;
                    act = reduce_top();
                    if (act != ACT_NONE) begin
                        run[2] = word_now(act);
                        n = 3;
                    end
                end
            end
            run[n - 1].last_of_run = 1'b1;
            run[n - 1].accepted = fin && shadow_depth == 1 && shadow_stack[0] == SYM_E;
            for (int k = 0; k < n; k++) words_due.push_back(run[k]);
        end
        if (fin) shadow_depth = 0;
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        err_count++;
    endtask

    task automatic send_word(input logic [7:0] c, input logic fin);
        int gap;
        gap = (src_jitter && $urandom_range(0, 1) == 1) ? idle_len() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      = 1'b1;
        i_char_in    = c;
        i_final_char = fin;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        parse_char(c, fin);
        if (c != SYM_SPACE) chars_sent++;
    endtask

    task automatic send_text();
        for (int k = 0; k < text_buf.size(); k++) begin
            send_word(text_buf[k], k == text_buf.size() - 1);
        end
        text_buf.delete();
    endtask

    task automatic put_text(input string s);
        for (int k = 0; k < s.len(); k++) text_buf.push_back(s[k]);
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (words_due.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_symbol();
        case ($urandom_range(0, 6))
            0: return SYM_A;
            1: return SYM_PLUS;
            2: return SYM_TIMES;
            3: return SYM_LPAR;
            4: return SYM_RPAR;
            5: return SYM_E;
            default: return SYM_SPACE;
        endcase
    endfunction

    task automatic gen_expr(input int lvl);
        int pick;
        pick = (lvl == 0) ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 5) == 0) text_buf.push_back(SYM_SPACE);
        case (pick)
            0: text_buf.push_back(SYM_A);
            1: begin
                gen_expr(lvl - 1);
                text_buf.push_back(SYM_PLUS);
                gen_expr(lvl - 1);
            end
            2: begin
                gen_expr(lvl - 1);
                text_buf.push_back(SYM_TIMES);
                gen_expr(lvl - 1);
            end
            default: begin
                text_buf.push_back(SYM_LPAR);
                gen_expr(lvl - 1);
                text_buf.push_back(SYM_RPAR);
            end
        endcase
    endtask

    task automatic test_directed_strings();
        src_jitter  = 1'b0;
        sink_jitter = 1'b0;
        put_text("a");
        send_text();
        put_text("a+a");
        send_text();
        put_text("a*a");
        send_text();
        put_text("(a)");
        send_text();
        put_text("a + a ");
        send_text();
        put_text("a+");
        send_text();
        text_buf.push_back(8'h00);
        text_buf.push_back(8'hFF);
        text_buf.push_back(SYM_E);
        send_text();
        put_text("E");
        send_text();
        put_text(" ");
        send_text();
        wait_results_drained();
    endtask

    task automatic test_stack_overflow();
        logic [7:0] c;
        src_jitter  = 1'b1;
        sink_jitter = 1'b1;
        // fill with symbols that never match a rule
        repeat (STACK_N) begin
            c = 8'($urandom_range(0, 255));
            if (c == SYM_A || c == SYM_RPAR || c == SYM_E || c == SYM_SPACE) c = SYM_LPAR;
            text_buf.push_back(c);
        end
        text_buf.push_back(SYM_A);
        text_buf.push_back(SYM_E);
        text_buf.push_back(SYM_RPAR);
        send_text();
        wait_results_drained();
    endtask

    task automatic test_receiver_hold();
        int start;
        src_jitter = 1'b0;
        hold_len   = HOLD_CYCLES;
        start      = chars_sent;
        while (chars_sent - start < HOLD_CHARS) begin
            gen_expr(3);
            send_text();
        end
        src_jitter = 1'b1;
        wait_results_drained();
    endtask

    task automatic test_random_strings();
        int start;
        int kind;
        int pos;
        start = chars_sent;
        while (chars_sent - start < RANDOM_CHARS) begin
            kind = $urandom_range(0, 9);
            if (kind < 9) gen_expr($urandom_range(0, 4));
            if (kind == 7 || kind == 8) begin
                pos = $urandom_range(0, text_buf.size() - 1);
                case ($urandom_range(0, 2))
                    0: text_buf.delete(pos);
                    1: text_buf[pos] = 8'($urandom_range(0, 255));
                    default: text_buf.insert(pos, pick_symbol());
                endcase
            end else if (kind == 9) begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 1) == 0) text_buf.push_back(8'($urandom_range(0, 255)));
                    else text_buf.push_back(pick_symbol());
                end
            end
            if ($urandom_range(0, 3) == 0) text_buf.push_back(SYM_SPACE);
            if (text_buf.size() == 0) text_buf.push_back(SYM_A);
            send_text();
            if ($urandom_range(0, 7) == 0) begin
                wait_results_drained();
                src_jitter  = 1'($urandom_range(0, 1));
                sink_jitter = 1'($urandom_range(0, 1));
            end
        end
    endtask

    initial begin : sink_pacing
        int stall_left;
        stall_left = 0;
        i_stall    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_len > 0) begin
                stall_left = hold_len;
                hold_len   = 0;
            end else if (stall_left == 0 && sink_jitter && $urandom_range(0, 9) < 3) begin
                stall_left = idle_len();
            end
            i_stall = (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    always @(posedge i_clk) begin : check_words
        t_parse_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (words_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word action=%0d depth=%0d top=%02h",
                                          o_action, o_depth, o_top_symbol));
            end else begin
                want = words_due.pop_front();
                if (o_action !== want.action)
                    report_mismatch($sformatf("action %0d, want %0d", o_action, want.action));
                if (o_depth !== want.depth)
                    report_mismatch($sformatf("depth %0d, want %0d", o_depth, want.depth));
                if (o_top_symbol !== want.top_symbol)
                    report_mismatch($sformatf("top %02h, want %02h", o_top_symbol,
                                              want.top_symbol));
                if (o_accepted !== want.accepted)
                    report_mismatch($sformatf("accepted %0b, want %0b", o_accepted,
                                              want.accepted));
                if (o_last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %0b, want %0b", o_last_of_run,
                                              want.last_of_run));
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : run_tests
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_char_in    = 8'h00;
        i_final_char = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_strings();
        test_stack_overflow();
        test_receiver_hold();
        test_random_strings();
        wait_results_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
